FILE: hdl/huff_pkg.sv
// Shared types, constants and helper functions for the Huffman encoder bit packer.
package huff_pkg;

	localparam int MAX_CODE_LEN = 32;
	localparam int BYTE_W = 8;
	localparam int SYM_W = 8;
	localparam int NUM_SYM = 256;
	localparam int CODE_W = 32;
	localparam int LEN_W = 6;
	localparam int PEND_W = BYTE_W - 1;
	localparam int CNT_W = $clog2(BYTE_W);
	localparam int ENTRY_W = CODE_W + LEN_W;
	localparam int STREAM_W = PEND_W + MAX_CODE_LEN;
	localparam int MAX_BYTES = (PEND_W + MAX_CODE_LEN) / BYTE_W;
	localparam int GROUP_W = MAX_BYTES * BYTE_W;
	localparam int SHIFT_W = GROUP_W + BYTE_W;
	localparam int TOT_W = $clog2(STREAM_W + 1);
	localparam int SH_AMT_W = $clog2(SHIFT_W + 1);
	localparam int REM_W = $clog2(MAX_BYTES + 1);

	typedef enum logic [1:0] {
		CMD_LOAD   = 2'd0,
		CMD_ENCODE = 2'd1,
		CMD_FLUSH  = 2'd2
	} cmd_t;

	typedef struct packed {
		cmd_t              cmd;
		logic [SYM_W-1:0]  symbol;
		logic [CODE_W-1:0] code_bits;
		logic [LEN_W-1:0]  code_length;
	} req_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              last_of_run;
	} res_t;

	typedef struct packed {
		logic              vld;
		cmd_t              cmd;
		logic [CODE_W-1:0] bits;
		logic [LEN_W-1:0]  len;
	} look_t;

	// Saturates the length and drops code bits above it before the entry is stored.
	function automatic logic [ENTRY_W-1:0] make_entry(input logic [CODE_W-1:0] bits,
		input logic [LEN_W-1:0] len);
		logic [LEN_W-1:0]  l;
		logic [CODE_W-1:0] m;
		l = (len > LEN_W'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN) : len;
		if (l < LEN_W'(CODE_W)) begin
			m = bits & ((CODE_W'(1) << l) - CODE_W'(1));
		end else begin
			m = bits;
		end
		return {m, l};
	endfunction

endpackage

FILE: hdl/huff_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module huff_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: hdl/huff_table.sv
// Code table storage, entry valid bits and the lookup stage.
module huff_table (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           take,
	input  huff_pkg::req_t req,
	input  logic           adv,
	output huff_pkg::look_t look
);

	import huff_pkg::*;

	logic [NUM_SYM-1:0] hit_q;
	logic               vld_s1;
	cmd_t               cmd_s1;
	logic               hit_s1;
	logic [ENTRY_W-1:0] rdata;
	logic               we;
	logic               re;

	assign we = take && (req.cmd == CMD_LOAD);
	assign re = take && (req.cmd == CMD_ENCODE);

	huff_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(NUM_SYM)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(req.symbol),
		.wdata(make_entry(req.code_bits, req.code_length)),
		.re   (re),
		.raddr(req.symbol),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= '0;
			vld_s1 <= 1'b0;
			hit_s1 <= 1'b0;
		end else begin
			if (we) begin
				hit_q[req.symbol] <= 1'b1;
			end
			if (take) begin
				vld_s1 <= 1'b1;
				hit_s1 <= hit_q[req.symbol];
			end else if (adv) begin
				vld_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= req.cmd;
		end
	end

	always_comb begin
		look.vld = vld_s1;
		look.cmd = cmd_s1;
		look.bits = hit_s1 ? rdata[ENTRY_W-1:LEN_W] : '0;
		look.len = hit_s1 ? rdata[LEN_W-1:0] : '0;
	end

endmodule

FILE: hdl/huff_pack.sv
// Bit packer with pending-bit state and the output byte queue.
module huff_pack (
	input  logic            clk,
	input  logic            arst_n,
	input  huff_pkg::look_t look,
	output logic            adv,
	output huff_pkg::res_t  res,
	output logic            res_valid,
	input  logic            res_ready
);

	import huff_pkg::*;

	logic [PEND_W-1:0]   pend_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [GROUP_W-1:0]  grp_q;
	logic [REM_W-1:0]    rem_q;
	logic [LEN_W-1:0]    eff_len;
	logic [CODE_W-1:0]   word;
	logic [STREAM_W-1:0] v;
	logic [TOT_W-1:0]    tot;
	logic [REM_W-1:0]    nbytes;
	logic [CNT_W-1:0]    new_cnt;
	logic [SHIFT_W-1:0]  x;
	logic [PEND_W-1:0]   new_pend;
	logic [BYTE_W-1:0]   keep_mask;
	logic                grp_free;
	logic                pop;

	always_comb begin
		case (look.cmd)
			CMD_ENCODE: begin
				eff_len = look.len;
				word = look.bits;
			end
			CMD_FLUSH: begin
				eff_len = (cnt_q == '0) ? '0 : LEN_W'(BYTE_W) - LEN_W'(cnt_q);
				word = '0;
			end
			default: begin
				eff_len = '0;
				word = '0;
			end
		endcase
		v = (STREAM_W'(pend_q) << eff_len) | STREAM_W'(word);
		tot = TOT_W'(cnt_q) + TOT_W'(eff_len);
		nbytes = REM_W'(tot[TOT_W-1:CNT_W]);
		new_cnt = tot[CNT_W-1:0];
		x = SHIFT_W'(v) << (SH_AMT_W'(SHIFT_W) - SH_AMT_W'(tot));
		keep_mask = (BYTE_W'(1) << new_cnt) - BYTE_W'(1);
		new_pend = v[PEND_W-1:0] & keep_mask[PEND_W-1:0];
	end

	assign pop = res_valid && res_ready;
	assign grp_free = (rem_q == '0) || ((rem_q == REM_W'(1)) && res_ready);
	assign adv = look.vld && ((nbytes == '0) || grp_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			cnt_q <= '0;
			rem_q <= '0;
		end else begin
			if (adv) begin
				pend_q <= new_pend;
				cnt_q <= new_cnt;
			end
			if (adv && (nbytes != '0)) begin
				rem_q <= nbytes;
			end else if (pop) begin
				rem_q <= rem_q - REM_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && (nbytes != '0)) begin
			grp_q <= x[SHIFT_W-1 -: GROUP_W];
		end else if (pop) begin
			grp_q <= grp_q << BYTE_W;
		end
	end

	assign res_valid = (rem_q != '0);
	assign res.out_byte = grp_q[GROUP_W-1 -: BYTE_W];
	assign res.last_of_run = (rem_q == REM_W'(1));

endmodule

FILE: hdl/huffman_encode_bit_packer.sv
// Top level of the Huffman encoder bit packer.
// A load request writes one symbol's code word and length into a 256-entry code table held
// in a synchronous RAM, an encode request looks up its symbol and appends the code bits MSB
// first to a partial byte, and a flush request pads the partial byte with zeros and sends it.
// Every completed byte goes out on the result channel in order, the final byte of a request
// marked with last_of_run. A request that completes no byte never waits on the output, so such
// requests may follow each other in every cycle. A request that completes bytes holds them in
// the output register, which sends one byte per cycle while res_ready is high, and the next
// byte-producing request waits behind it; a request passes the table read register and is then
// packed into the output register. Reset marks every table entry as unloaded at once, so no
// clearing pass is needed.
module huffman_encode_bit_packer (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  huff_pkg::req_t req,
	output logic           res_valid,
	input  logic           res_ready,
	output huff_pkg::res_t res
);

	import huff_pkg::*;

	look_t look;
	logic  adv;
	logic  take;

	assign req_ready = !look.vld || adv;
	assign take = req_valid && req_ready;

	huff_table u_table (
		.clk   (clk),
		.arst_n(arst_n),
		.take  (take),
		.req   (req),
		.adv   (adv),
		.look  (look)
	);

	huff_pack u_pack (
		.clk      (clk),
		.arst_n   (arst_n),
		.look     (look),
		.adv      (adv),
		.res      (res),
		.res_valid(res_valid),
		.res_ready(res_ready)
	);

endmodule

FILE: hdl/huff_chk.sv
// Port-level checker for the Huffman encoder bit packer and its bind statement.
module huff_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input logic           res_valid,
	input logic           res_ready,
	input huff_pkg::res_t res
);

	import huff_pkg::*;

	logic acc;

	assign acc = req_valid && req_ready;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("Result changed or dropped while stalled.");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && !res.last_of_run |=> res_valid)
		else $error("A run of bytes stopped before its last byte.");

	a_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid && !acc && $past(!acc) |=> !res_valid)
		else $error("A result appeared without a recent request.");

endmodule

bind huffman_encode_bit_packer huff_chk u_chk (.*);

FILE: tb/huffman_encode_bit_packer_test.sv
// Self-checking testbench for the Huffman encoder bit packer: code table loads, encodes and flushes.
module huffman_encode_bit_packer_test;
	timeunit 1ns;
	timeprecision 1ps;

	import huff_pkg::*;

	localparam cmd_t CMD_UNUSED = cmd_t'(2'd3);
	localparam int STALL_LIMIT = 1000;
	localparam int DRAIN_CYCLES = 20;
	localparam int REPORT_MAX = 10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	res_t res;

	bit idle_on = 1'b1;
	int fail_count = 0;
	int stall_cycles = 0;

	logic [CODE_W-1:0] code_words [NUM_SYM];
	logic [LEN_W-1:0] code_lens [NUM_SYM];
	logic [PEND_W-1:0] pend_bits = '0;
	logic [CNT_W-1:0] pend_cnt = '0;
	res_t expected_bytes[$];

	huffman_encode_bit_packer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	initial begin
		forever begin
			#5 clk = ~clk;
		end
	end

	function automatic req_t mk_req(input cmd_t c, input logic [SYM_W-1:0] s,
		input logic [CODE_W-1:0] bits, input logic [LEN_W-1:0] len);
		req_t r;
		r.cmd = c;
		r.symbol = s;
		r.code_bits = bits;
		r.code_length = len;
		return r;
	endfunction

	function automatic void queue_byte(input res_t b);
		expected_bytes = {expected_bytes, b};
	endfunction

	function automatic void pack_request(input req_t r);
		logic [LEN_W-1:0] n;
		logic [BYTE_W-1:0] acc;
		int cnt;
		int produced;
		res_t b;
		produced = 0;
		case (r.cmd)
			CMD_LOAD: begin
				n = (r.code_length > LEN_W'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN) : r.code_length;
				code_lens[r.symbol] = n;
				if (n >= LEN_W'(CODE_W)) begin
					code_words[r.symbol] = r.code_bits;
				end else begin
					code_words[r.symbol] = r.code_bits & ~({CODE_W{1'b1}} << n);
				end
			end
			CMD_ENCODE: begin
				acc = {1'b0, pend_bits};
				cnt = pend_cnt;
				for (int i = int'(code_lens[r.symbol]) - 1; i >= 0; i--) begin
					acc = {acc[BYTE_W-2:0], code_words[r.symbol][i]};
					cnt++;
					if (cnt == BYTE_W) begin
						b.out_byte = acc;
						b.last_of_run = 1'b0;
						queue_byte(b);
						produced++;
						acc = '0;
						cnt = 0;
					end
				end
				if (produced > 0) begin
					expected_bytes[expected_bytes.size() - 1].last_of_run = 1'b1;
				end
				pend_bits = acc[PEND_W-1:0];
				pend_cnt = CNT_W'(cnt);
			end
			CMD_FLUSH: begin
				if (pend_cnt != '0) begin
					acc = {1'b0, pend_bits};
					acc = acc << (BYTE_W - int'(pend_cnt));
					b.out_byte = acc;
					b.last_of_run = 1'b1;
					queue_byte(b);
					pend_bits = '0;
					pend_cnt = '0;
				end
			end
			default: begin
			end
		endcase
	endfunction

	// The handshake is sampled at the falling edge, where it holds until the next rising edge.
	task automatic send_req(input req_t r);
		bit taken;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = req_ready;
			@(posedge clk);
		end
		pack_request(r);
	endtask

	task automatic test_load_limits();
		send_req(mk_req(CMD_LOAD, 8'd0, 32'hFFFF_FFFF, 6'd63));
		send_req(mk_req(CMD_LOAD, 8'd255, 32'h1234_5678, 6'd33));
		send_req(mk_req(CMD_LOAD, 8'd7, 32'hFFFF_FFFF, 6'd5));
		send_req(mk_req(CMD_LOAD, 8'd8, 32'hFFFF_FFFF, 6'd0));
		send_req(mk_req(CMD_ENCODE, 8'd0, 32'h0, 6'd0));
		send_req(mk_req(CMD_ENCODE, 8'd255, 32'hFFFF_FFFF, 6'd63));
		send_req(mk_req(CMD_ENCODE, 8'd7, 32'h0, 6'd0));
		send_req(mk_req(CMD_ENCODE, 8'd8, 32'h0, 6'd0));
		send_req(mk_req(CMD_FLUSH, 8'd0, 32'h0, 6'd0));
	endtask

	task automatic test_flush();
		send_req(mk_req(CMD_FLUSH, 8'd0, 32'h0, 6'd0));
		send_req(mk_req(CMD_LOAD, 8'd1, 32'h0000_0005, 6'd3));
		send_req(mk_req(CMD_ENCODE, 8'd1, 32'h0, 6'd0));
		send_req(mk_req(CMD_FLUSH, 8'hFF, 32'hFFFF_FFFF, 6'd63));
		send_req(mk_req(CMD_FLUSH, 8'd0, 32'h0, 6'd0));
	endtask

	task automatic test_unused_cmd();
		send_req(mk_req(CMD_UNUSED, 8'd1, 32'hFFFF_FFFF, 6'd1));
		send_req(mk_req(CMD_ENCODE, 8'd1, 32'h0, 6'd0));
		send_req(mk_req(CMD_FLUSH, 8'd0, 32'h0, 6'd0));
	endtask

	task automatic test_unloaded_symbol();
		send_req(mk_req(CMD_ENCODE, 8'd200, 32'hFFFF_FFFF, 6'd32));
		send_req(mk_req(CMD_FLUSH, 8'd0, 32'h0, 6'd0));
	endtask

	// Each round loads a few symbols, then mostly encodes those, with some noise mixed in.
	task automatic test_random_traffic(input int n_items);
		int sent;
		int pick;
		logic [SYM_W-1:0] loaded[$];
		logic [SYM_W-1:0] s;
		logic [LEN_W-1:0] len;
		sent = 0;
		while (sent < n_items) begin
			loaded.delete();
			repeat ($urandom_range(2, 8)) begin
				s = SYM_W'($urandom_range(0, 255));
				len = ($urandom_range(0, 7) == 0) ? LEN_W'($urandom_range(0, 63)) :
					LEN_W'($urandom_range(1, 32));
				loaded = {loaded, s};
				send_req(mk_req(CMD_LOAD, s, $urandom, len));
				sent++;
			end
			repeat ($urandom_range(6, 24)) begin
				pick = $urandom_range(0, 19);
				if (pick == 0) begin
					send_req(mk_req(CMD_FLUSH, SYM_W'($urandom_range(0, 255)), $urandom,
						LEN_W'($urandom_range(0, 63))));
					sent++;
				end else if (pick == 1) begin
					send_req(mk_req(CMD_UNUSED, SYM_W'($urandom_range(0, 255)), $urandom,
						LEN_W'($urandom_range(0, 63))));
				end else begin
					s = (pick == 2) ? SYM_W'($urandom_range(0, 255)) :
						loaded[$urandom_range(0, loaded.size() - 1)];
					send_req(mk_req(CMD_ENCODE, s, $urandom, LEN_W'($urandom_range(0, 63))));
					sent++;
				end
			end
		end
	endtask

	task automatic test_full_rate();
		idle_on = 1'b0;
		test_random_traffic(40);
		send_req(mk_req(CMD_FLUSH, 8'd0, 32'h0, 6'd0));
	endtask

	task automatic note_mismatch(input string what, input res_t want, input res_t got);
		fail_count++;
		if (fail_count <= REPORT_MAX) begin
			$display("%0t %s: expected byte %02h last %0b, got byte %02h last %0b", $realtime, what,
				want.out_byte, want.last_of_run, got.out_byte, got.last_of_run);
		end
	endtask

	initial begin
		res_t want;
		forever begin
			@(negedge clk);
			if (arst_n && res_valid && res_ready) begin
				if (expected_bytes.size() == 0) begin
					note_mismatch("unexpected byte", '0, res);
				end else begin
					want = expected_bytes.pop_front();
					if (res.out_byte !== want.out_byte || res.last_of_run !== want.last_of_run) begin
						note_mismatch("wrong byte", want, res);
					end
				end
			end
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (idle_on && $urandom_range(0, 5) == 0) begin
				res_ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				res_ready <= 1'b1;
				repeat ($urandom_range(0, 30)) @(posedge clk);
			end else begin
				res_ready <= 1'b1;
			end
		end
	end

	initial begin
		forever begin
			@(negedge clk);
			if (!arst_n || (req_valid && req_ready) || (res_valid && res_ready)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
			end
			if (stall_cycles >= STALL_LIMIT) begin
				$display("huffman_encode_bit_packer: mismatch");
				$finish;
			end
		end
	end

	initial begin
		for (int i = 0; i < NUM_SYM; i++) begin
			code_words[i] = '0;
			code_lens[i] = '0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_load_limits();
		test_flush();
		test_unused_cmd();
		test_unloaded_symbol();
		test_random_traffic(250);
		test_full_rate();
		req_valid <= 1'b0;
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("huffman_encode_bit_packer: match");
		end else begin
			$display("huffman_encode_bit_packer: mismatch");
		end
		$finish;
	end

endmodule
